### design/anti_replay_window_check_macros.svh
// ----------------------------------------------------------------------------
// Anti-replay window check: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ANTI_REPLAY_WINDOW_CHECK_MACROS_SVH
`define ANTI_REPLAY_WINDOW_CHECK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARWC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/arwc_pkg.sv
// ----------------------------------------------------------------------------
// Anti-replay window check: package
// Window geometry, bitmap word layout, verdict codes and the queue entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arwc_pkg;

    localparam int COUNTER_W   = 64;
    localparam int VERDICT_W   = 2;

    // The window size must be a power of two between 64 and 8192.
    localparam int WINDOW_BITS = 1024;
    localparam int WIN_IDX_W   = $clog2(WINDOW_BITS);

    localparam int WORD_BITS   = 32;
    localparam int WORD_OFF_W  = $clog2(WORD_BITS);
    localparam int WORD_CNT_W  = $clog2(WORD_BITS + 1);
    localparam int NUM_WORDS   = WINDOW_BITS / WORD_BITS;
    localparam int WORD_ADDR_W = WIN_IDX_W - WORD_OFF_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VERDICT_W-1:0] VERDICT_OK       = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_RESERVED = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_TOO_OLD  = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_REPLAY   = 2'd3;

    typedef enum logic [2:0] {
        KIND_RESERVED,
        KIND_TOO_OLD,
        KIND_OLDER,
        KIND_SPAN,
        KIND_JUMP
    } arwc_kind_t;

    typedef struct packed {
        arwc_kind_t           kind;
        logic [WIN_IDX_W-1:0] slot;
        logic [WIN_IDX_W-1:0] start;
        logic [WIN_IDX_W-1:0] jump;
    } arwc_entry_t;

endpackage

### design/arwc_if.sv
// ----------------------------------------------------------------------------
// Anti-replay window check: channel interfaces
// Valid/ready channels for counter items and verdict items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arwc_in_if
    import arwc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COUNTER_W-1:0] packet_counter;

    modport source (output valid, output packet_counter, input ready);
    modport sink (input valid, input packet_counter, output ready);
    modport monitor (input valid, input packet_counter, input ready);
endinterface

interface arwc_out_if
    import arwc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [VERDICT_W-1:0] verdict;

    modport source (output valid, output accepted, output verdict, input ready);
    modport sink (input valid, input accepted, input verdict, output ready);
    modport monitor (input valid, input accepted, input verdict, input ready);
endinterface

### design/arwc_ram.sv
// ----------------------------------------------------------------------------
// Anti-replay window check: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/arwc_queue.sv
// ----------------------------------------------------------------------------
// Anti-replay window check: classified item queue
// Short FIFO between the classifier and the bitmap engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arwc_queue
    import arwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  arwc_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output arwc_entry_t pop_data,
    output logic        empty
);

    arwc_entry_t            entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/arwc_front.sv
// ----------------------------------------------------------------------------
// Anti-replay window check: classifier
// Accepts counter items, compares them with the highest counter seen and
// queues the class of work that the bitmap engine has to do.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arwc_front
    import arwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    arwc_in_if.sink     request,
    output logic        push,
    output arwc_entry_t push_data,
    input  logic        full
);

    logic [COUNTER_W-1:0] highest_reg;
    logic [COUNTER_W-1:0] counter;
    logic [COUNTER_W-1:0] diff_up;
    logic [COUNTER_W-1:0] diff_down;
    logic                 is_reserved;
    logic                 is_newer;
    logic                 far_up;
    logic                 far_down;

    assign counter     = request.packet_counter;
    assign request.ready = !full;
    assign push        = request.valid && !full;

    assign is_reserved = (counter == '1);
    assign is_newer    = (counter > highest_reg);
    assign diff_up     = counter - highest_reg;
    assign diff_down   = highest_reg - counter;
    assign far_up      = |diff_up[COUNTER_W-1:WIN_IDX_W];
    assign far_down    = |diff_down[COUNTER_W-1:WIN_IDX_W];

    always_comb
    begin
        push_data.slot  = counter[WIN_IDX_W-1:0];
        push_data.start = highest_reg[WIN_IDX_W-1:0] + 1'b1;
        push_data.jump  = diff_up[WIN_IDX_W-1:0];
        if (is_reserved)
        begin
            push_data.kind = KIND_RESERVED;
        end
        else if (is_newer)
        begin
            push_data.kind = far_up ? KIND_JUMP : KIND_SPAN;
        end
        else
        begin
            push_data.kind = far_down ? KIND_TOO_OLD : KIND_OLDER;
        end
    end

    // A newer counter other than the reserved value is always accepted, so the highest counter moves here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_reg <= '0;
        end
        else if (push && !is_reserved && is_newer)
        begin
            highest_reg <= counter;
        end
    end

endmodule

### design/arwc_back.sv
// ----------------------------------------------------------------------------
// Anti-replay window check: bitmap engine
// Carries out queued items on the word-organised seen bitmap and holds the
// verdict item until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arwc_back
    import arwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  arwc_entry_t pop_data,
    output logic        pop,
    arwc_out_if.source  response
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MODIFY
    } state_t;

    state_t               state_reg;
    arwc_kind_t           kind_reg;
    logic [WIN_IDX_W-1:0] slot_reg;
    logic [WIN_IDX_W-1:0] pos_reg;
    logic [WIN_IDX_W-1:0] rem_reg;
    logic [NUM_WORDS-1:0] word_valid_reg;
    logic                 out_valid_reg;
    logic                 out_accepted_reg;
    logic [VERDICT_W-1:0] out_verdict_reg;

    logic                   out_free;
    logic                   out_load;
    logic                   ram_we;
    logic [WORD_ADDR_W-1:0] ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [WORD_ADDR_W-1:0] ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;
    logic [WORD_ADDR_W-1:0] head_word;
    logic [WORD_ADDR_W-1:0] cur_word;
    logic [WORD_BITS-1:0]   cur_data;
    logic [WORD_BITS-1:0]   slot_bit;
    logic [WORD_BITS-1:0]   span_mask;
    logic [WORD_CNT_W-1:0]  avail;
    logic [WIN_IDX_W-1:0]   step;
    logic                   last;
    logic                   bit_set;

    arwc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || response.ready;
    assign pop      = (state_reg == ST_IDLE) && !empty && out_free;

    assign out_load = ((state_reg == ST_IDLE) && pop &&
                       (pop_data.kind inside {KIND_RESERVED, KIND_TOO_OLD, KIND_JUMP})) ||
                      ((state_reg == ST_MODIFY) && ((kind_reg != KIND_SPAN) || last));

    assign head_word = pop_data.slot[WIN_IDX_W-1:WORD_OFF_W];
    assign cur_word  = (kind_reg == KIND_OLDER) ? slot_reg[WIN_IDX_W-1:WORD_OFF_W] :
                                                  pos_reg[WIN_IDX_W-1:WORD_OFF_W];
    assign ram_raddr = cur_word;
    assign cur_data  = word_valid_reg[cur_word] ? ram_rdata : '0;
    assign slot_bit  = WORD_BITS'(1) << slot_reg[WORD_OFF_W-1:0];
    assign bit_set   = |(cur_data & slot_bit);

    assign avail = WORD_CNT_W'(WORD_BITS) - WORD_CNT_W'(pos_reg[WORD_OFF_W-1:0]);
    assign step  = (rem_reg < WIN_IDX_W'(avail)) ? rem_reg : WIN_IDX_W'(avail);
    assign last  = (rem_reg == step);

    always_comb
    begin
        logic [WIN_IDX_W:0] lo_ext;
        logic [WIN_IDX_W:0] hi_ext;
        lo_ext = (WIN_IDX_W + 1)'(pos_reg[WORD_OFF_W-1:0]);
        hi_ext = lo_ext + {1'b0, step};
        for (int i = 0; i < WORD_BITS; i++)
        begin
            span_mask[i] = ((WIN_IDX_W + 1)'(i) >= lo_ext) &&
                           ((WIN_IDX_W + 1)'(i) < hi_ext);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_word;
        ram_wdata = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && (pop_data.kind == KIND_JUMP))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = head_word;
                    ram_wdata = WORD_BITS'(1) << pop_data.slot[WORD_OFF_W-1:0];
                end
            end
            ST_MODIFY:
            begin
                if (kind_reg == KIND_SPAN)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = (cur_data & ~span_mask) | (last ? slot_bit : '0);
                end
                else if (!bit_set)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = cur_data | slot_bit;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            kind_reg         <= KIND_RESERVED;
            slot_reg         <= '0;
            pos_reg          <= '0;
            rem_reg          <= '0;
            word_valid_reg   <= '0;
            out_valid_reg    <= 1'b0;
            out_accepted_reg <= 1'b0;
            out_verdict_reg  <= VERDICT_OK;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        kind_reg <= pop_data.kind;
                        slot_reg <= pop_data.slot;
                        pos_reg  <= pop_data.start;
                        rem_reg  <= pop_data.jump;
                        case (pop_data.kind)
                            KIND_RESERVED:
                            begin
                                out_accepted_reg <= 1'b0;
                                out_verdict_reg  <= VERDICT_RESERVED;
                            end
                            KIND_TOO_OLD:
                            begin
                                out_accepted_reg <= 1'b0;
                                out_verdict_reg  <= VERDICT_TOO_OLD;
                            end
                            KIND_JUMP:
                            begin
                                word_valid_reg   <= NUM_WORDS'(1) << head_word;
                                out_accepted_reg <= 1'b1;
                                out_verdict_reg  <= VERDICT_OK;
                            end
                            KIND_OLDER, KIND_SPAN:
                            begin
                                state_reg <= ST_READ;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_MODIFY;
                end
                ST_MODIFY:
                begin
                    if (kind_reg == KIND_SPAN)
                    begin
                        word_valid_reg[cur_word] <= 1'b1;
                        pos_reg <= pos_reg + step;
                        rem_reg <= rem_reg - step;
                        if (last)
                        begin
                            out_accepted_reg <= 1'b1;
                            out_verdict_reg  <= VERDICT_OK;
                            state_reg        <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                    else
                    begin
                        if (bit_set)
                        begin
                            out_accepted_reg <= 1'b0;
                            out_verdict_reg  <= VERDICT_REPLAY;
                        end
                        else
                        begin
                            word_valid_reg[cur_word] <= 1'b1;
                            out_accepted_reg <= 1'b1;
                            out_verdict_reg  <= VERDICT_OK;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign response.valid    = out_valid_reg;
    assign response.accepted = out_accepted_reg;
    assign response.verdict  = out_verdict_reg;

endmodule

### design/anti_replay_window_check.sv
// ----------------------------------------------------------------------------
// Anti-replay window check: top level
// Sliding-window replay filter over 64-bit packet counters, built from a
// classifier, a two-entry queue and a bitmap engine on a word RAM.
//
//   Channel    Role    Payload
//   request    sink    packet_counter[63:0]
//   response   source  accepted, verdict[1:0]
//
// Items pass through the queue to the bitmap engine. The engine settles a
// reserved, too-old or far-ahead counter from idle, a counter inside the window
// with a read and an update of one 32-bit bitmap word, and an advance that
// clears slots across N words with a read and an update per word, N at most
// WINDOW_BITS/32 + 1. The engine's read-modify-write loop sets the rate.
// Reset clears one valid flag per bitmap word; there is no clearing pass.
// The queue keeps taking items while a verdict waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anti_replay_window_check
    import arwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    arwc_in_if.sink    request,
    arwc_out_if.source response
);

    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    arwc_entry_t push_data;
    arwc_entry_t pop_data;

    arwc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    arwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    arwc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .response (response)
    );

endmodule

### design/arwc_checker.sv
// ----------------------------------------------------------------------------
// Anti-replay window check: port checker
// Concurrent assertions on the verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "anti_replay_window_check_macros.svh"

module arwc_checker
    import arwc_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    arwc_in_if.sink      request,
    arwc_out_if.source   response
);

    `ARWC_ASSERT_NEXT(a_resp_hold, response.valid && !response.ready, response.valid && $stable(response.accepted) && $stable(response.verdict), "verdict item changed while stalled")
    `ARWC_ASSERT_SAME(a_accept_code, response.valid, response.accepted == (response.verdict == VERDICT_OK), "accepted flag disagrees with verdict")
    `ARWC_ASSERT_SAME(a_quiet_after_reset, $past(!rst_n), !response.valid, "verdict item shown straight after reset")
    `ARWC_ASSERT_SAME(a_ready_after_reset, $past(!rst_n), request.ready, "request not ready straight after reset")

endmodule

bind anti_replay_window_check arwc_checker u_arwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .request  (request),
    .response (response)
);
